// ----- rtl/flpms_pkg.sv -----
`default_nettype none

package flpms_pkg;

	// Pool geometry. A link holds a slot number or the null code, which is
	// one past the last slot.
	localparam int POOL_SIZE = 1024;
	localparam int SLOT_W    = $clog2(POOL_SIZE);
	localparam int LINK_W    = SLOT_W + 1;
	localparam int COUNT_W   = SLOT_W + 1;

	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SIZE);

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_SWEEP = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/free_list_pool_mark_sweep.sv -----
`default_nettype none

// Slot pool allocator with a linked free list and a mark bitmap. Each input word carries a
// command: allocate pops the head slot of the free list (or reports pool_empty), mark sets
// the mark bit of one slot, sweep walks every slot in ascending order, pushes each unmarked
// slot onto a new free list, counts the marked ones, clears all marks and reports the count,
// and code 3 does nothing. Every command gives exactly one result word. The block works on
// one command at a time. Allocate and mark wait until the output side is free, allocate
// being bound also by the registered read of the link memory. A sweep does one
// mark-memory read per slot and one link-memory write for each unmarked slot.
// After reset the block runs a clearing pass over the mark memory, one entry per cycle,
// and holds in_stall high until every entry has been cleared. The link memory needs no
// clearing: until the first sweep every link is known to be the slot number plus one, so
// allocate computes it instead of reading it. A finished result sits in the output
// register while the next command is accepted.

module free_list_pool_mark_sweep (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic [1:0]                     cmd,
	input  wire logic [flpms_pkg::SLOT_W-1:0]   slot_index,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic [flpms_pkg::SLOT_W-1:0]   alloc_slot,
	output      logic                           pool_empty,
	output      logic [flpms_pkg::COUNT_W-1:0]  live_count
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC,
		ST_SWEEP,
		ST_DONE
	} state_t;

	state_t state_q;

	// Head of the free list; during a sweep it collects the new list.
	logic [flpms_pkg::LINK_W-1:0]  head_q;
	// Set by the first sweep, after which link memory contents are valid.
	logic                          linked_q;
	// Walk pointer for the clearing pass and the sweep read side.
	logic [flpms_pkg::LINK_W-1:0]  ptr_q;
	// Slot whose mark bit arrives from memory in this sweep cycle.
	logic [flpms_pkg::SLOT_W-1:0]  proc_idx_s1;

	// Pending result until the output register can take it.
	logic [flpms_pkg::SLOT_W-1:0]  res_slot_q;
	logic                          res_empty_q;
	logic [flpms_pkg::COUNT_W-1:0] res_live_q;

	logic                          out_valid_q;
	logic [flpms_pkg::SLOT_W-1:0]  alloc_slot_q;
	logic                          pool_empty_q;
	logic [flpms_pkg::COUNT_W-1:0] live_count_q;

	logic                          accept;
	logic                          out_free;
	flpms_pkg::cmd_t               in_cmd;
	logic                          mark_in_range;
	logic                          sweep_last;
	logic [flpms_pkg::COUNT_W-1:0] live_next;

	logic                          link_we;
	logic [flpms_pkg::SLOT_W-1:0]  link_waddr;
	logic [flpms_pkg::LINK_W-1:0]  link_wdata;
	logic                          link_re;
	logic [flpms_pkg::SLOT_W-1:0]  link_raddr;
	logic [flpms_pkg::LINK_W-1:0]  link_rdata;

	logic                          mark_we;
	logic [flpms_pkg::SLOT_W-1:0]  mark_waddr;
	logic [0:0]                    mark_wdata;
	logic                          mark_re;
	logic [flpms_pkg::SLOT_W-1:0]  mark_raddr;
	logic [0:0]                    mark_rdata;

	assign in_stall      = (state_q != ST_IDLE);
	assign accept        = in_valid && !in_stall;
	assign out_free      = !out_valid_q || !out_stall;
	assign in_cmd        = flpms_pkg::cmd_t'(cmd);
	assign mark_in_range = ({1'b0, slot_index} < flpms_pkg::LINK_NULL);
	assign sweep_last    = (ptr_q == flpms_pkg::LINK_NULL);
	assign live_next     = res_live_q + flpms_pkg::COUNT_W'(mark_rdata[0]);

	assign out_valid  = out_valid_q;
	assign alloc_slot = alloc_slot_q;
	assign pool_empty = pool_empty_q;
	assign live_count = live_count_q;

	// Memory port control. The sweep reads slot k while it retires slot k-1,
	// so a read and a write never meet on the same entry.
	always_comb begin
		link_we    = 1'b0;
		link_waddr = proc_idx_s1;
		link_wdata = head_q;
		link_re    = 1'b0;
		link_raddr = head_q[flpms_pkg::SLOT_W-1:0];
		mark_we    = 1'b0;
		mark_waddr = proc_idx_s1;
		mark_wdata = 1'b0;
		mark_re    = 1'b0;
		mark_raddr = ptr_q[flpms_pkg::SLOT_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				mark_we    = 1'b1;
				mark_waddr = ptr_q[flpms_pkg::SLOT_W-1:0];
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						flpms_pkg::CMD_ALLOC: begin
							link_re = linked_q && (head_q != flpms_pkg::LINK_NULL);
						end
						flpms_pkg::CMD_MARK: begin
							mark_we    = mark_in_range;
							mark_waddr = slot_index;
							mark_wdata = 1'b1;
						end
						flpms_pkg::CMD_SWEEP: begin
							mark_re    = 1'b1;
							mark_raddr = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SWEEP: begin
				link_we = !mark_rdata[0];
				mark_we = 1'b1;
				mark_re = !sweep_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			head_q       <= '0;
			linked_q     <= 1'b0;
			ptr_q        <= '0;
			proc_idx_s1  <= '0;
			res_slot_q   <= '0;
			res_empty_q  <= 1'b0;
			res_live_q   <= '0;
			out_valid_q  <= 1'b0;
			alloc_slot_q <= '0;
			pool_empty_q <= 1'b0;
			live_count_q <= '0;
		end else begin
			// In the result states a taken word is replaced by the new one below.
			if (out_valid_q && !out_stall && state_q != ST_ALLOC && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q[flpms_pkg::SLOT_W-1:0] ==
					    flpms_pkg::SLOT_W'(flpms_pkg::POOL_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_slot_q  <= '0;
						res_empty_q <= 1'b0;
						res_live_q  <= '0;
						state_q     <= ST_DONE;
						case (in_cmd)
							flpms_pkg::CMD_ALLOC: begin
								if (head_q == flpms_pkg::LINK_NULL) begin
									res_empty_q <= 1'b1;
								end else begin
									res_slot_q <= head_q[flpms_pkg::SLOT_W-1:0];
									state_q    <= ST_ALLOC;
								end
							end
							flpms_pkg::CMD_SWEEP: begin
								// The new list starts empty; slot 0 is being read.
								head_q      <= flpms_pkg::LINK_NULL;
								linked_q    <= 1'b1;
								ptr_q       <= flpms_pkg::LINK_W'(1);
								proc_idx_s1 <= '0;
								state_q     <= ST_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ALLOC: begin
					if (out_free) begin
						// Before the first sweep the list is still ascending.
						head_q       <= linked_q ? link_rdata : (head_q + 1'b1);
						out_valid_q  <= 1'b1;
						alloc_slot_q <= res_slot_q;
						pool_empty_q <= 1'b0;
						live_count_q <= '0;
						state_q      <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					// A marked slot is counted; an unmarked one is pushed.
					if (mark_rdata[0]) begin
						res_live_q <= live_next;
					end else begin
						head_q <= {1'b0, proc_idx_s1};
					end
					if (sweep_last) begin
						state_q <= ST_DONE;
					end else begin
						proc_idx_s1 <= ptr_q[flpms_pkg::SLOT_W-1:0];
						ptr_q       <= ptr_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						alloc_slot_q <= res_slot_q;
						pool_empty_q <= res_empty_q;
						live_count_q <= res_live_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	flpms_ram #(
		.WIDTH(flpms_pkg::LINK_W),
		.DEPTH(flpms_pkg::POOL_SIZE)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	flpms_ram #(
		.WIDTH(1),
		.DEPTH(flpms_pkg::POOL_SIZE)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (mark_re),
		.raddr (mark_raddr),
		.rdata (mark_rdata)
	);

endmodule

`default_nettype wire

// ----- rtl/flpms_ram.sv -----
`default_nettype none

module flpms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read word holds its value until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
